// ===== src/pcwe_pkg.sv =====
// ----------------------------------------------------------------------------
// pcwe_pkg: shared types and constants for the pointing cosine block
// Widths of the shared multiplier and of the shift-subtract unit, and the
// request/response bundles that pass between the sequencer and that unit.
// ----------------------------------------------------------------------------
package pcwe_pkg;

	localparam int MUL_W  = 33;  // signed multiplier operand
	localparam int PROD_W = 66;  // registered product
	localparam int REM_W  = 66;  // partial remainder
	localparam int SRC_W  = 64;  // dividend / radicand bits fed from the top
	localparam int QUO_W  = 64;  // quotient or root
	localparam int DIV_W  = 62;  // divisor
	localparam int STEP_W = 7;   // iteration count

	localparam logic signed [14:0] G_LIMIT = 15'sd8192;

	typedef logic signed [MUL_W-1:0]  mul_op_t;
	typedef logic signed [PROD_W-1:0] mul_prod_t;

	typedef struct packed {
		logic              start;
		logic              sqrt_mode;
		logic [STEP_W-1:0] steps;
	} ssu_req_t;

	typedef struct packed {
		logic done;
		logic sat;
	} ssu_rsp_t;

endpackage

// ===== src/pcwe_mul.sv =====
// ----------------------------------------------------------------------------
// pcwe_mul: shared signed multiplier
// One 33x33 signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module pcwe_mul (
	input  logic                clk,
	input  pcwe_pkg::mul_op_t   a,
	input  pcwe_pkg::mul_op_t   b,
	output pcwe_pkg::mul_prod_t p
);
	import pcwe_pkg::*;

	mul_prod_t p_q;

	always_ff @(posedge clk) begin
		p_q <= mul_prod_t'(a) * mul_prod_t'(b);
	end

	assign p = p_q;

endmodule

// ===== src/pcwe_ssu.sv =====
// ----------------------------------------------------------------------------
// pcwe_ssu: shared shift-subtract unit
// Restoring division (one quotient bit per cycle) or digit-by-digit square
// root (one root bit per cycle). Quotient bits shifted out of the top are
// collected into a sticky overflow flag.
// ----------------------------------------------------------------------------
module pcwe_ssu (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcwe_pkg::ssu_req_t            req,
	input  logic [pcwe_pkg::REM_W-1:0]    rem_init,
	input  logic [pcwe_pkg::SRC_W-1:0]    src,
	input  logic [pcwe_pkg::DIV_W-1:0]    divisor,
	output pcwe_pkg::ssu_rsp_t            rsp,
	output logic [pcwe_pkg::QUO_W-1:0]    quo
);
	import pcwe_pkg::*;

	logic              run_q;
	logic              done_q;
	logic              sqrt_q;
	logic [STEP_W-1:0] cnt_q;

	logic [REM_W-1:0] rem_q;
	logic [SRC_W-1:0] src_q;
	logic [DIV_W-1:0] div_q;
	logic [QUO_W-1:0] quo_q;
	logic             sat_q;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic [REM_W-1:0] rem_n;
	logic             ge;

	always_comb begin
		if (sqrt_q) begin
			rem_sh = {rem_q[REM_W-3:0], src_q[SRC_W-1 -: 2]};
			trial  = {quo_q, 2'b01};
		end else begin
			rem_sh = {rem_q[REM_W-2:0], src_q[SRC_W-1]};
			trial  = REM_W'(div_q);
		end
		ge    = (rem_sh >= trial);
		rem_n = ge ? (rem_sh - trial) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			sqrt_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q  <= 1'b1;
				sqrt_q <= req.sqrt_mode;
				cnt_q  <= req.steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= rem_init;
			src_q <= src;
			div_q <= divisor;
			quo_q <= '0;
			sat_q <= 1'b0;
		end else if (run_q) begin
			rem_q <= rem_n;
			src_q <= sqrt_q ? {src_q[SRC_W-3:0], 2'b00} : {src_q[SRC_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
			sat_q <= sat_q | quo_q[QUO_W-1];
		end
	end

	assign rsp.done = done_q;
	assign rsp.sat  = sat_q;
	assign quo      = quo_q;

endmodule

// ===== src/pointing_cosine_with_error.sv =====
// ----------------------------------------------------------------------------
// pointing_cosine_with_error: cosine between two vectors with its error
// Holds a decay-length vector and covariance; a momentum transaction gives
// the Q2.30 cosine and its first-order propagated error.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  input    | start & !busy        | command, comp_x/y/z, var_*, cov_*
//  result   | done (1-cycle pulse) | cosine, cosine_error, zero_norm,
//           |                      | error_saturated
//
//  A load transaction (command 0) is taken in the idle state; busy stays low.
//  A compute transaction keeps busy high until done, with almost all of that
//  time in the one-bit-per-cycle shift-subtract unit: one root and three
//  divisions per vector, one long division per error term with a positive
//  quadratic form (49..111 steps, set by the vector's normalizing shift) and,
//  unless the error saturated, a final root. A zero vector ends it early.
//  Reset clears the held vector and covariance, so a compute before any load
//  reports zero_norm. Results cannot be stalled: done lasts one cycle.
//
module pointing_cosine_with_error (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [31:0] comp_x,
	input  logic [31:0] comp_y,
	input  logic [31:0] comp_z,
	input  logic [31:0] var_xx,
	input  logic [31:0] var_yy,
	input  logic [31:0] var_zz,
	input  logic [31:0] cov_xy,
	input  logic [31:0] cov_xz,
	input  logic [31:0] cov_yz,
	output logic        done,
	output logic [31:0] cosine,
	output logic [31:0] cosine_error,
	output logic        zero_norm,
	output logic        error_saturated
);
	import pcwe_pkg::*;

	typedef enum logic [16:0] {
		S_IDLE  = 17'h00001,
		S_NLOAD = 17'h00002,
		S_NORM  = 17'h00004,
		S_SQ    = 17'h00008,
		S_RSQ   = 17'h00010,
		S_WSQ   = 17'h00020,
		S_RDIV  = 17'h00040,
		S_WDIV  = 17'h00080,
		S_DOT   = 17'h00100,
		S_COS   = 17'h00200,
		S_GRAD  = 17'h00400,
		S_QUAD  = 17'h00800,
		S_REDIV = 17'h01000,
		S_WEDIV = 17'h02000,
		S_FSQ   = 17'h04000,
		S_WFSQ  = 17'h08000,
		S_OUT   = 17'h10000
	} state_t;

	// operand pairs of the quadratic form: xx, yy, zz, xy, xz, yz
	localparam logic [1:0] QI [6] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1};
	localparam logic [1:0] QJ [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

	state_t state_q;

	// held L and latched P
	logic [31:0] lvec_q [3];
	logic [31:0] lcov_q [6];
	logic [31:0] pvec_q [3];
	logic [31:0] pcov_q [6];

	// sequencing
	logic       vsel_q;   // 0: L, 1: P
	logic       gsel_q;   // 0: P error term, 1: L error term
	logic [1:0] ix_q;
	logic [3:0] mc_q;

	// unit-vector working set
	logic [31:0]        m_q [3];
	logic [2:0]         neg_q;
	logic signed [5:0]  k_q;
	logic signed [31:0] ul_q [3];
	logic signed [31:0] up_q [3];
	logic [30:0]        nl_q, np_q;
	logic signed [5:0]  kl_q, kp_q;

	// cosine and error
	logic signed [63:0] acc_q;
	logic signed [31:0] c_q;
	logic signed [14:0] g_q [3];
	logic signed [27:0] gg_q [6];
	logic [61:0]        nsq_q;
	logic [63:0]        vsum_q;
	logic               sat_q;

	logic [31:0] cos_q, err_q;
	logic        zn_q, es_q;

	// shared units
	mul_op_t    mul_a, mul_b;
	mul_prod_t  mul_p;
	ssu_req_t   ssu_req;
	ssu_rsp_t   ssu_rsp;
	logic [REM_W-1:0] ssu_rem;
	logic [SRC_W-1:0] ssu_src;
	logic [DIV_W-1:0] ssu_div;
	logic [QUO_W-1:0] ssu_quo;

	// helpers
	logic [31:0]       raw [3];
	logic [31:0]       rab [3];
	logic              zero_raw;
	logic              too_big, too_small;
	logic [3:0]        cm;
	logic [2:0]        gidx;
	logic [30:0]       n_side;
	logic signed [5:0] k_side;
	logic signed [7:0] esteps;
	logic              q_pos;
	logic [64:0]       vsum_n;
	logic [31:0]       cov_sel;
	logic [31:0]       udiv;

	function automatic logic [31:0] abs32(input logic [31:0] x);
		abs32 = x[31] ? (~x + 32'd1) : x;
	endfunction

	// Gradient term: a - trunc(p / 2^30), then trunc by 2^17 and clamp.
	function automatic logic signed [14:0] grad_f(input logic signed [31:0] a,
			input logic signed [PROD_W-1:0] p);
		logic signed [35:0] t1;
		logic signed [35:0] t;
		logic signed [18:0] t2;
		t1 = $signed(p[65:30]);
		if (p[65] && (p[29:0] != '0)) begin
			t1 = t1 + 36'sd1;
		end
		t  = 36'(a) - t1;
		t2 = $signed(t[35:17]);
		if (t[35] && (t[16:0] != '0)) begin
			t2 = t2 + 19'sd1;
		end
		if (t2 > 19'(G_LIMIT)) begin
			t2 = 19'(G_LIMIT);
		end else if (t2 < -19'(G_LIMIT)) begin
			t2 = -19'(G_LIMIT);
		end
		grad_f = t2[14:0];
	endfunction

	// cosine: round |s| / 2^30 half away from zero, clamp to 1.0, sign of s
	function automatic logic signed [31:0] cos_f(input logic signed [63:0] s);
		logic [63:0] sa;
		logic [33:0] mg;
		sa = s[63] ? (~s + 64'd1) : s;
		mg = 34'((sa + 64'd536870912) >> 30);
		if (mg > 34'd1073741824) begin
			mg = 34'd1073741824;
		end
		cos_f = s[63] ? $signed(~mg[31:0] + 32'd1) : $signed(mg[31:0]);
	endfunction

	pcwe_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	pcwe_ssu u_ssu (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (ssu_req),
		.rem_init (ssu_rem),
		.src      (ssu_src),
		.divisor  (ssu_div),
		.rsp      (ssu_rsp),
		.quo      (ssu_quo)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			raw[i] = vsel_q ? pvec_q[i] : lvec_q[i];
			rab[i] = abs32(raw[i]);
		end
		zero_raw  = (rab[0] == '0) && (rab[1] == '0) && (rab[2] == '0);
		// normalize so the largest magnitude sits in [2^29, 2^30)
		too_big   = |{m_q[0][31:30], m_q[1][31:30], m_q[2][31:30]};
		too_small = ~|{m_q[0][31:29], m_q[1][31:29], m_q[2][31:29]};
		cm        = mc_q - 4'd1;
		gidx      = 3'(mc_q - 4'd6);
		n_side    = gsel_q ? nl_q : np_q;
		k_side    = gsel_q ? kl_q : kp_q;
		// error division runs 3 + (2k + 50) steps
		esteps    = 8'sd53 + (8'(k_side) <<< 1);
		q_pos     = !acc_q[63] && (acc_q != '0);
		vsum_n    = {1'b0, vsum_q} + {1'b0, ssu_quo};
		cov_sel   = gsel_q ? lcov_q[gidx] : pcov_q[gidx];
		udiv      = neg_q[ix_q] ? (~ssu_quo[31:0] + 32'd1) : ssu_quo[31:0];
	end

	// multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQ: begin
				if (mc_q < 4'd3) begin
					mul_a = mul_op_t'({1'b0, m_q[mc_q[1:0]]});
					mul_b = mul_op_t'({1'b0, m_q[mc_q[1:0]]});
				end
			end
			S_DOT: begin
				if (mc_q < 4'd3) begin
					mul_a = mul_op_t'(ul_q[mc_q[1:0]]);
					mul_b = mul_op_t'(up_q[mc_q[1:0]]);
				end
			end
			S_GRAD: begin
				if (mc_q < 4'd3) begin
					mul_a = mul_op_t'(c_q);
					mul_b = gsel_q ? mul_op_t'(ul_q[mc_q[1:0]]) : mul_op_t'(up_q[mc_q[1:0]]);
				end
			end
			S_QUAD: begin
				if (mc_q < 4'd6) begin
					mul_a = mul_op_t'(g_q[QI[mc_q[2:0]]]);
					mul_b = mul_op_t'(g_q[QJ[mc_q[2:0]]]);
				end else if (mc_q < 4'd12) begin
					mul_a = mul_op_t'(gg_q[gidx]);
					mul_b = (gidx < 3'd3) ? mul_op_t'({1'b0, cov_sel})
						: mul_op_t'($signed(cov_sel));
				end else if (mc_q == 4'd12) begin
					mul_a = mul_op_t'({1'b0, n_side});
					mul_b = mul_op_t'({1'b0, n_side});
				end
			end
			default: begin
			end
		endcase
	end

	// shift-subtract unit requests
	always_comb begin
		ssu_req = '0;
		ssu_rem = '0;
		ssu_src = '0;
		ssu_div = '0;
		case (state_q)
			S_RSQ: begin
				ssu_req.start     = 1'b1;
				ssu_req.sqrt_mode = 1'b1;
				ssu_req.steps     = STEP_W'(32);
				ssu_src           = {2'b00, acc_q[61:0]};
			end
			S_RDIV: begin
				// m * 2^30 / n; top bits of m already below n
				ssu_req.start = 1'b1;
				ssu_req.steps = STEP_W'(31);
				ssu_rem       = REM_W'(m_q[ix_q] >> 1);
				ssu_src       = {m_q[ix_q][0], 63'd0};
				ssu_div       = DIV_W'(vsel_q ? np_q : nl_q);
			end
			S_REDIV: begin
				// Q * 2^(2k+50) / n^2; Q < 2^61 and n^2 >= 2^58
				ssu_req.start = q_pos;
				ssu_req.steps = esteps[STEP_W-1:0];
				ssu_rem       = REM_W'(acc_q[63:3]);
				ssu_src       = {acc_q[2:0], 61'd0};
				ssu_div       = nsq_q;
			end
			S_FSQ: begin
				ssu_req.start     = !sat_q;
				ssu_req.sqrt_mode = 1'b1;
				ssu_req.steps     = STEP_W'(32);
				ssu_src           = vsum_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer and held L
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vsel_q  <= 1'b0;
			gsel_q  <= 1'b0;
			ix_q    <= '0;
			mc_q    <= '0;
			for (int i = 0; i < 3; i++) begin
				lvec_q[i] <= '0;
			end
			for (int i = 0; i < 6; i++) begin
				lcov_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (!command) begin
							lvec_q <= '{comp_x, comp_y, comp_z};
							lcov_q <= '{var_xx, var_yy, var_zz, cov_xy, cov_xz, cov_yz};
						end else begin
							vsel_q  <= 1'b0;
							state_q <= S_NLOAD;
						end
					end
				end
				S_NLOAD: begin
					state_q <= zero_raw ? S_OUT : S_NORM;
				end
				S_NORM: begin
					if (!too_big && !too_small) begin
						mc_q    <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					mc_q <= mc_q + 4'd1;
					if (mc_q == 4'd3) begin
						state_q <= S_RSQ;
					end
				end
				S_RSQ: begin
					state_q <= S_WSQ;
				end
				S_WSQ: begin
					if (ssu_rsp.done) begin
						ix_q    <= '0;
						state_q <= S_RDIV;
					end
				end
				S_RDIV: begin
					state_q <= S_WDIV;
				end
				S_WDIV: begin
					if (ssu_rsp.done) begin
						if (ix_q == 2'd2) begin
							if (!vsel_q) begin
								vsel_q  <= 1'b1;
								state_q <= S_NLOAD;
							end else begin
								mc_q    <= '0;
								state_q <= S_DOT;
							end
						end else begin
							ix_q    <= ix_q + 2'd1;
							state_q <= S_RDIV;
						end
					end
				end
				S_DOT: begin
					mc_q <= mc_q + 4'd1;
					if (mc_q == 4'd3) begin
						state_q <= S_COS;
					end
				end
				S_COS: begin
					mc_q    <= '0;
					gsel_q  <= 1'b0;
					state_q <= S_GRAD;
				end
				S_GRAD: begin
					if (mc_q == 4'd3) begin
						mc_q    <= '0;
						state_q <= S_QUAD;
					end else begin
						mc_q <= mc_q + 4'd1;
					end
				end
				S_QUAD: begin
					mc_q <= mc_q + 4'd1;
					if (mc_q == 4'd13) begin
						state_q <= S_REDIV;
					end
				end
				S_REDIV: begin
					if (q_pos) begin
						state_q <= S_WEDIV;
					end else if (!gsel_q) begin
						gsel_q  <= 1'b1;
						mc_q    <= '0;
						state_q <= S_GRAD;
					end else begin
						state_q <= S_FSQ;
					end
				end
				S_WEDIV: begin
					if (ssu_rsp.done) begin
						if (!gsel_q) begin
							gsel_q  <= 1'b1;
							mc_q    <= '0;
							state_q <= S_GRAD;
						end else begin
							state_q <= S_FSQ;
						end
					end
				end
				S_FSQ: begin
					state_q <= sat_q ? S_OUT : S_WFSQ;
				end
				S_WFSQ: begin
					if (ssu_rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start && command) begin
					pvec_q <= '{comp_x, comp_y, comp_z};
					pcov_q <= '{var_xx, var_yy, var_zz, cov_xy, cov_xz, cov_yz};
					sat_q  <= 1'b0;
					vsum_q <= '0;
				end
			end
			S_NLOAD: begin
				for (int i = 0; i < 3; i++) begin
					m_q[i]   <= rab[i];
					neg_q[i] <= raw[i][31];
				end
				k_q <= '0;
				if (zero_raw) begin
					cos_q <= '0;
					err_q <= '0;
					zn_q  <= 1'b1;
					es_q  <= 1'b0;
				end
			end
			S_NORM: begin
				if (too_big) begin
					for (int i = 0; i < 3; i++) begin
						m_q[i] <= m_q[i] >> 1;
					end
					k_q <= k_q - 6'sd1;
				end else if (too_small) begin
					for (int i = 0; i < 3; i++) begin
						m_q[i] <= m_q[i] << 1;
					end
					k_q <= k_q + 6'sd1;
				end else begin
					acc_q <= '0;
				end
			end
			S_SQ, S_DOT: begin
				if (mc_q != 4'd0) begin
					acc_q <= acc_q + mul_p[63:0];
				end
			end
			S_WSQ: begin
				if (ssu_rsp.done) begin
					if (vsel_q) begin
						np_q <= ssu_quo[30:0];
						kp_q <= k_q;
					end else begin
						nl_q <= ssu_quo[30:0];
						kl_q <= k_q;
					end
				end
			end
			S_WDIV: begin
				if (ssu_rsp.done) begin
					if (vsel_q) begin
						up_q[ix_q] <= $signed(udiv);
					end else begin
						ul_q[ix_q] <= $signed(udiv);
					end
					acc_q <= '0;
				end
			end
			S_COS: begin
				c_q <= cos_f(acc_q);
			end
			S_GRAD: begin
				if (mc_q != 4'd0) begin
					g_q[cm[1:0]] <= grad_f(gsel_q ? up_q[cm[1:0]] : ul_q[cm[1:0]], mul_p);
				end
				if (mc_q == 4'd3) begin
					acc_q <= '0;
				end
			end
			S_QUAD: begin
				if (mc_q != 4'd0) begin
					if (cm < 4'd6) begin
						gg_q[cm[2:0]] <= $signed(mul_p[27:0]);
					end else if (cm < 4'd9) begin
						acc_q <= acc_q + mul_p[63:0];
					end else if (cm < 4'd12) begin
						// cross terms count twice
						acc_q <= acc_q + {mul_p[62:0], 1'b0};
					end else begin
						nsq_q <= mul_p[61:0];
					end
				end
			end
			S_WEDIV: begin
				if (ssu_rsp.done) begin
					vsum_q <= vsum_n[63:0];
					sat_q  <= sat_q | ssu_rsp.sat | vsum_n[64];
				end
			end
			S_FSQ: begin
				if (sat_q) begin
					cos_q <= c_q;
					err_q <= '1;
					zn_q  <= 1'b0;
					es_q  <= 1'b1;
				end
			end
			S_WFSQ: begin
				if (ssu_rsp.done) begin
					cos_q <= c_q;
					err_q <= ssu_quo[31:0];
					zn_q  <= 1'b0;
					es_q  <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = (state_q == S_OUT);
	assign cosine          = cos_q;
	assign cosine_error    = err_q;
	assign zero_norm       = zn_q;
	assign error_saturated = es_q;

endmodule

// ===== verif/pointing_cosine_with_error_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pointing_cosine_with_error_tb: self-checking bench for the pointing cosine
// Loads decay-length vectors, sends momentum transactions, predicts cosine and
// propagated error in fixed point and compares every done pulse in order.
// ----------------------------------------------------------------------------
module pointing_cosine_with_error_tb;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_COMPUTE = 1'b1;
	localparam int   HALF_HI     = 6;
	localparam int   HALF_LO     = 6;
	localparam int   N_RANDOM    = 1730;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct {
		logic        command;
		logic [31:0] comp[3];
		logic [31:0] cov[6];   // xx, yy, zz, xy, xz, yz
	} xact_t;

	typedef struct {
		logic [31:0] cosine;
		logic [31:0] cosine_error;
		logic        zero_norm;
		logic        error_saturated;
	} cos_result_t;

	typedef struct {
		longint u[3];
		longint unsigned n;
		int k;
		bit zero;
	} unit_t;

	// ---------------------------------------------------------------- predictor
	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic unit_t normalize(logic [31:0] raw[3]);
		unit_t o;
		longint unsigned m[3], mx, sum;
		bit neg[3];
		longint s;
		int k;
		mx = 0; sum = 0; k = 0;
		for (int i = 0; i < 3; i++) begin
			s = longint'($signed(raw[i]));
			neg[i] = s < 0;
			m[i] = neg[i] ? -s : s;
			if (m[i] > mx) mx = m[i];
		end
		o.zero = (mx == 0);
		o.k = 0; o.n = 1;
		for (int i = 0; i < 3; i++) o.u[i] = 0;
		if (o.zero) return o;
		while (mx >= (64'd1 << 30)) begin mx >>= 1; k--; end
		while (mx < (64'd1 << 29)) begin mx <<= 1; k++; end
		for (int i = 0; i < 3; i++) begin
			m[i] = (k < 0) ? (m[i] >> (-k)) : (m[i] << k);
			sum += m[i] * m[i];
		end
		o.n = int_sqrt(sum);
		o.k = k;
		for (int i = 0; i < 3; i++) begin
			s = longint'((m[i] << 30) / o.n);
			o.u[i] = neg[i] ? -s : s;
		end
		return o;
	endfunction

	function automatic longint gradient_form(longint a[3], longint b[3], longint c,
	                                        logic [31:0] cov[6]);
		longint g[3], t, q;
		for (int i = 0; i < 3; i++) begin
			t = a[i] - (c * b[i]) / (64'sd1 <<< 30);
			t = t / 131072;
			if (t > 8192) t = 8192;
			if (t < -8192) t = -8192;
			g[i] = t;
		end
		q = g[0]*g[0]*longint'({32'd0, cov[0]}) + g[1]*g[1]*longint'({32'd0, cov[1]})
		  + g[2]*g[2]*longint'({32'd0, cov[2]});
		q += 2 * (g[0]*g[1]*longint'($signed(cov[3])) + g[0]*g[2]*longint'($signed(cov[4]))
		        + g[1]*g[2]*longint'($signed(cov[5])));
		return q;
	endfunction

	function automatic longint unsigned error_share(longint q, unit_t v, ref bit sat);
		longint unsigned qq, r, d;
		int e;
		if (q <= 0) return 0;
		d = v.n * v.n;
		e = 2 * v.k + 50;
		qq = longint'(q) / d;
		r = longint'(q) % d;
		for (int i = 0; i < e; i++) begin
			if (qq >= (64'd1 << 63)) begin sat = 1; return 0; end
			qq <<= 1; r <<= 1;
			if (r >= d) begin r -= d; qq |= 1; end
		end
		return qq;
	endfunction

	// ---------------------------------------------------------------- scoreboard
	class cosine_board;
		logic [31:0] len_vec[3];
		logic [31:0] len_cov[6];
		cos_result_t pending[$];
		int errors;

		function new();
			foreach (len_vec[i]) len_vec[i] = '0;
			foreach (len_cov[i]) len_cov[i] = '0;
			errors = 0;
		endfunction

		function void note_input(xact_t x);
			unit_t lv, pv;
			cos_result_t r;
			longint s, c;
			longint unsigned mag, vp, vl, v;
			bit sat;
			if (x.command == CMD_LOAD) begin
				len_vec = x.comp;
				len_cov = x.cov;
				return;
			end
			lv = normalize(len_vec);
			pv = normalize(x.comp);
			r = '{default: '0};
			if (lv.zero || pv.zero) begin
				r.zero_norm = 1;
				pending.push_back(r);
				return;
			end
			s = 0;
			for (int i = 0; i < 3; i++) s += lv.u[i] * pv.u[i];
			mag = (s < 0) ? -s : s;
			mag = (mag + (64'd1 << 29)) >> 30;
			if (mag > (64'd1 << 30)) mag = 64'd1 << 30;
			c = (s < 0) ? -longint'(mag) : longint'(mag);
			sat = 0;
			vp = error_share(gradient_form(lv.u, pv.u, c, x.cov), pv, sat);
			vl = error_share(gradient_form(pv.u, lv.u, c, len_cov), lv, sat);
			v = vp + vl;
			if (v < vp) sat = 1;
			r.cosine = c[31:0];
			r.cosine_error = sat ? 32'hFFFF_FFFF : 32'(int_sqrt(v));
			r.error_saturated = sat;
			pending.push_back(r);
		endfunction

		function void check_result(cos_result_t got);
			cos_result_t e;
			if (pending.size() == 0) begin
				$error("result with no transaction pending");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.cosine !== e.cosine) begin
				$error("cosine exp %0d got %0d", $signed(e.cosine), $signed(got.cosine));
				errors++;
			end
			if (got.cosine_error !== e.cosine_error) begin
				$error("cosine_error exp %0d got %0d", e.cosine_error, got.cosine_error);
				errors++;
			end
			if (got.zero_norm !== e.zero_norm) begin
				$error("zero_norm exp %0b got %0b", e.zero_norm, got.zero_norm);
				errors++;
			end
			if (got.error_saturated !== e.error_saturated) begin
				$error("error_saturated exp %0b got %0b", e.error_saturated,
					got.error_saturated);
				errors++;
			end
		endfunction
	endclass

	// ---------------------------------------------------------------- DUT
	logic        clk, arst_n, start, busy, command, done, zero_norm, error_saturated;
	logic [31:0] comp_x, comp_y, comp_z, var_xx, var_yy, var_zz, cov_xy, cov_xz, cov_yz;
	logic [31:0] cosine, cosine_error;

	pointing_cosine_with_error i_dut (.*);

	cosine_board board;
	longint      cycles;
	bit          quiet;   // no idle bursts in the closing stretch

	always begin
		clk = 1'b1; #HALF_HI;
		clk = 1'b0; #HALF_LO;
	end

	// Results cannot be stalled: sample every done pulse at the edge ending it.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done)
			board.check_result('{cosine, cosine_error, zero_norm, error_saturated});
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("pointing_cosine_with_error_tb: done, errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus
	// Drive one transaction and hold start until the edge where busy is low.
	task automatic send(xact_t x);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		command <= x.command;
		comp_x  <= x.comp[0]; comp_y <= x.comp[1]; comp_z <= x.comp[2];
		var_xx  <= x.cov[0];  var_yy <= x.cov[1];  var_zz <= x.cov[2];
		cov_xy  <= x.cov[3];  cov_xz <= x.cov[4];  cov_yz <= x.cov[5];
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_input(x);
	endtask

	function automatic logic [31:0] rand_word();
		// mix of small, edge and full-range values
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, 16'($urandom)};
			2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			3: return 32'($signed(20'($urandom)));
			default: return $urandom;
		endcase
	endfunction

	function automatic xact_t make_xact(logic cmd, bit wild);
		xact_t x;
		x.command = cmd;
		for (int i = 0; i < 3; i++) x.comp[i] = rand_word();
		if ($urandom_range(0, 20) == 0) x.comp = '{32'h0, 32'h0, 32'h0};
		for (int i = 0; i < 6; i++)
			x.cov[i] = wild ? $urandom : (i < 3 ? 32'($urandom_range(0, 1 << 20))
			                                    : 32'($signed(16'($urandom))));
		return x;
	endfunction

	function automatic xact_t vec(logic cmd, logic [31:0] a, logic [31:0] b,
	                              logic [31:0] c, logic [31:0] v, logic [31:0] k);
		xact_t x;
		x.command = cmd;
		x.comp = '{a, b, c};
		x.cov  = '{v, v, v, k, k, k};
		return x;
	endfunction

	initial begin
		board   = new();
		cycles  = 0;
		quiet   = 0;
		arst_n  = 1'b0;
		start   = 1'b0;
		command = CMD_LOAD;
		{comp_x, comp_y, comp_z, var_xx, var_yy, var_zz, cov_xy, cov_xz, cov_yz} = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: compute before load, extremes, parallel, antiparallel,
		// indefinite covariance, saturating error, zero momentum
		send(vec(CMD_COMPUTE, 32'h0001_0000, 0, 0, 32'h1_0000, 0));
		send(vec(CMD_LOAD, 32'h0001_0000, 0, 0, 32'h1_0000, 0));
		send(vec(CMD_COMPUTE, 32'h0002_0000, 0, 0, 32'h1_0000, 0));
		send(vec(CMD_COMPUTE, 32'hFFFF_0000, 0, 0, 32'h1_0000, 0));
		send(vec(CMD_COMPUTE, 0, 32'h0001_0000, 0, 32'h1_0000, 0));
		send(vec(CMD_COMPUTE, 0, 0, 0, 32'h1_0000, 0));
		send(vec(CMD_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'hFFFF_FFFF, 32'h8000_0000));
		send(vec(CMD_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
			32'hFFFF_FFFF, 32'h7FFF_FFFF));
		send(vec(CMD_COMPUTE, 32'h1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send(vec(CMD_LOAD, 32'h1, 32'h1, 32'h1, 0, 32'h8000_0000));
		send(vec(CMD_COMPUTE, 32'h1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000));
		send(vec(CMD_COMPUTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
		send(vec(CMD_COMPUTE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
			32'h7FFF_FFFF, 32'h7FFF_FFFF));

		// random: mostly a load followed by a few computes
		for (int n = 0; n < N_RANDOM; ) begin
			if (n > N_RANDOM - 150) quiet = 1;
			send(make_xact(CMD_LOAD, $urandom_range(0, 3) == 0));
			n++;
			repeat ($urandom_range(1, 4)) begin
				send(make_xact($urandom_range(0, 9) == 0 ? CMD_LOAD : CMD_COMPUTE,
					$urandom_range(0, 3) == 0));
				n++;
			end
		end
		start <= 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (board.errors == 0)
			$display("pointing_cosine_with_error_tb: done, clean");
		else
			$display("pointing_cosine_with_error_tb: done, errors");
		$finish;
	end

endmodule
